@@ rtl/bpd_pkg.sv @@
// shared types and constants for the bounded position deque
package bpd_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int CMD_W        = 3;
	localparam int COORD_W      = 8;
	localparam int INDEX_W      = 8;
	localparam int COUNT_W      = 9;
	localparam int QUEUE_DEPTH  = 2;

	// command codes as they arrive on the request channel
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_QUERY    = 3'd4
	} cmd_t;

	// decoded operation handed from the front to the back
	typedef enum logic [2:0] {
		OP_INS_HEAD,
		OP_INS_TAIL,
		OP_REM_HEAD,
		OP_REM_TAIL,
		OP_QUERY,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] glyph;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} entry_t;

	typedef struct packed {
		op_kind_t           kind;
		entry_t             entry;
		logic [INDEX_W-1:0] read_index;
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD_HEAD,
		BK_RD_TAIL,
		BK_RD_ITEM,
		BK_CAPTURE,
		BK_PUSH
	} back_state_t;

endpackage

@@ rtl/bpd_if.sv @@
// request and response channel interfaces of the deque
interface bpd_req_if;
	import bpd_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [COORD_W-1:0] glyph;
	logic [INDEX_W-1:0] read_index;

	modport source (output valid, cmd, pos_x, pos_y, glyph, read_index, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, glyph, read_index, output ready);
endinterface

interface bpd_rsp_if;
	import bpd_pkg::*;

	logic               valid;
	logic               ready;
	logic               accepted;
	logic [COUNT_W-1:0] entry_count;
	logic [COORD_W-1:0] head_x;
	logic [COORD_W-1:0] head_y;
	logic [COORD_W-1:0] head_glyph;
	logic [COORD_W-1:0] tail_x;
	logic [COORD_W-1:0] tail_y;
	logic [COORD_W-1:0] tail_glyph;
	logic [COORD_W-1:0] item_x;
	logic [COORD_W-1:0] item_y;
	logic [COORD_W-1:0] item_glyph;
	logic               item_valid;

	modport source (output valid, accepted, entry_count, head_x, head_y, head_glyph,
		tail_x, tail_y, tail_glyph, item_x, item_y, item_glyph, item_valid,
		input ready);
	modport sink (input valid, accepted, entry_count, head_x, head_y, head_glyph,
		tail_x, tail_y, tail_glyph, item_x, item_y, item_glyph, item_valid,
		output ready);
endinterface

@@ rtl/bpd_front.sv @@
// front end: takes requests, decodes the command and packs the entry
module bpd_front (
	input  logic          clk,
	input  logic          arst_n,
	bpd_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output bpd_pkg::op_t  push_op
);
	import bpd_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_dec;

	always_comb begin
		op_dec.entry      = '{glyph: req.glyph, y: req.pos_y, x: req.pos_x};
		op_dec.read_index = req.read_index;
		case (cmd_t'(req.cmd))
			CMD_INS_HEAD: op_dec.kind = OP_INS_HEAD;
			CMD_INS_TAIL: op_dec.kind = OP_INS_TAIL;
			CMD_REM_HEAD: op_dec.kind = OP_REM_HEAD;
			CMD_REM_TAIL: op_dec.kind = OP_REM_TAIL;
			CMD_QUERY:    op_dec.kind = OP_QUERY;
			default:      op_dec.kind = OP_NOP;
		endcase
	end

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1 <= op_dec;
		end
	end
endmodule

@@ rtl/bpd_fifo.sv @@
// short operation queue between the front and the back
module bpd_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  bpd_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output bpd_pkg::op_t pop_op
);
	import bpd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != DEPTH_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end
endmodule

@@ rtl/bpd_back.sv @@
// back end: ring buffer of entries, applies operations and builds results
module bpd_back #(
	parameter int CAPACITY = bpd_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  bpd_pkg::op_t pop_op,
	bpd_rsp_if.source    rsp
);
	import bpd_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam logic [PTR_W:0]   CAP_EXT  = (PTR_W + 1)'(CAPACITY);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

	// ring addition, both operands below the capacity
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_EXT) begin
			s = s - CAP_EXT;
		end
		return s[PTR_W-1:0];
	endfunction

	back_state_t        state_q;
	back_state_t        state_d;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic               ok_q;
	logic [INDEX_W-1:0] idx_q;
	entry_t             head_e_q;
	entry_t             tail_e_q;
	entry_t             item_e_q;
	entry_t             mem [CAPACITY];
	entry_t             rd_data_q;

	logic               res_valid_q;
	logic               res_ok_q;
	logic [COUNT_W-1:0] res_count_q;
	entry_t             res_head_q;
	entry_t             res_tail_q;
	entry_t             res_item_q;
	logic               res_item_valid_q;

	logic             full;
	logic             empty;
	logic             item_hit;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] ins_ptr;
	logic [PTR_W-1:0] tail_ptr;
	logic [PTR_W-1:0] item_ptr;
	logic [PTR_W-1:0] rd_addr;
	logic             start;
	logic             res_load;

	logic             op_ok;
	logic [PTR_W-1:0] head_n;
	logic [CNT_W-1:0] count_n;
	logic             op_write;
	logic [PTR_W-1:0] mem_wa;

	assign full     = count_q == CAP_CNT;
	assign empty    = count_q == '0;
	assign item_hit = CMP_W'(idx_q) < CMP_W'(count_q);
	assign head_dec = (head_q == '0) ? LAST_PTR : head_q - PTR_W'(1);
	assign head_inc = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
	assign ins_ptr  = wrap_add(head_q, count_q[PTR_W-1:0]);
	assign tail_ptr = wrap_add(head_q, PTR_W'(count_q - CNT_W'(1)));
	assign item_ptr = wrap_add(head_q, PTR_W'(idx_q));

	// effect of the operation at the queue head on the ring state
	always_comb begin
		op_ok    = 1'b0;
		head_n   = head_q;
		count_n  = count_q;
		op_write = 1'b0;
		mem_wa   = ins_ptr;
		case (pop_op.kind)
			OP_INS_HEAD: begin
				if (!full) begin
					op_ok    = 1'b1;
					head_n   = head_dec;
					count_n  = count_q + CNT_W'(1);
					op_write = 1'b1;
					mem_wa   = head_dec;
				end
			end
			OP_INS_TAIL: begin
				if (!full) begin
					op_ok    = 1'b1;
					count_n  = count_q + CNT_W'(1);
					op_write = 1'b1;
				end
			end
			OP_REM_HEAD: begin
				if (!empty) begin
					op_ok   = 1'b1;
					head_n  = head_inc;
					count_n = count_q - CNT_W'(1);
				end
			end
			OP_REM_TAIL: begin
				if (!empty) begin
					op_ok   = 1'b1;
					count_n = count_q - CNT_W'(1);
				end
			end
			OP_QUERY: op_ok = 1'b1;
			default:  op_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = BK_RD_HEAD;
				end
			end
			BK_RD_HEAD: state_d = BK_RD_TAIL;
			BK_RD_TAIL: state_d = BK_RD_ITEM;
			BK_RD_ITEM: state_d = BK_CAPTURE;
			BK_CAPTURE: state_d = BK_PUSH;
			BK_PUSH: begin
				if (!res_valid_q || rsp.ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = state_q == BK_IDLE;
		start     = pop_valid && pop_ready;
		res_load  = (state_q == BK_PUSH) && (!res_valid_q || rsp.ready);
		case (state_q)
			BK_RD_HEAD: rd_addr = head_q;
			BK_RD_TAIL: rd_addr = tail_ptr;
			BK_RD_ITEM: rd_addr = item_ptr;
			default:    rd_addr = head_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				head_q  <= head_n;
				count_q <= count_n;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// single write port and one registered read port
	always_ff @(posedge clk) begin
		if (start && op_write) begin
			mem[mem_wa] <= pop_op.entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ok_q  <= op_ok;
			idx_q <= pop_op.read_index;
		end
		if (state_q == BK_RD_TAIL) begin
			head_e_q <= empty ? '0 : rd_data_q;
		end
		if (state_q == BK_RD_ITEM) begin
			tail_e_q <= empty ? '0 : rd_data_q;
		end
		if (state_q == BK_CAPTURE) begin
			item_e_q <= item_hit ? rd_data_q : '0;
		end
		if (res_load) begin
			res_ok_q         <= ok_q;
			res_count_q      <= COUNT_W'(count_q);
			res_head_q       <= head_e_q;
			res_tail_q       <= tail_e_q;
			res_item_q       <= item_e_q;
			res_item_valid_q <= item_hit;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.accepted    = res_ok_q;
	assign rsp.entry_count = res_count_q;
	assign rsp.head_x      = res_head_q.x;
	assign rsp.head_y      = res_head_q.y;
	assign rsp.head_glyph  = res_head_q.glyph;
	assign rsp.tail_x      = res_tail_q.x;
	assign rsp.tail_y      = res_tail_q.y;
	assign rsp.tail_glyph  = res_tail_q.glyph;
	assign rsp.item_x      = res_item_q.x;
	assign rsp.item_y      = res_item_q.y;
	assign rsp.item_glyph  = res_item_q.glyph;
	assign rsp.item_valid  = res_item_valid_q;
endmodule

@@ rtl/bounded_position_deque_core.sv @@
// top level of the bounded position deque
// A deque of up to CAPACITY entries (x, y, glyph). Requests arrive on req:
// cmd selects insert at head, insert at tail, remove head, remove tail or
// query; pos_x, pos_y and glyph give the entry to insert and read_index the
// position to report (0 is the head). Each request yields one response on
// rsp with the outcome, the count, head and tail entries and the indexed
// entry with its valid flag. Inserts into a full deque and removals from an
// empty one are refused with accepted low; unknown commands do nothing.
// Entries live in a ring buffer memory with one write and one read port.
// The back end steps through read head, read tail, read item, capture and
// push states for each request, set by the three reads (head, tail, indexed
// entry) through the single memory read port, and takes one request at a time.
// Decode and a two-entry queue ahead of the back end keep req ready while a
// response waits. When rsp stalls, the response is held and the back end
// waits; req stalls once the queue and the decode stage are full.
// arst_n empties the deque and drops everything in flight; memory contents
// are not cleared since entries at positions past the count never reach rsp.
module bounded_position_deque_core #(
	parameter int CAPACITY = bpd_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bpd_req_if.sink   req,
	bpd_rsp_if.source rsp
);
	import bpd_pkg::*;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	bpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	bpd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	bpd_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.rsp       (rsp)
	);

	// an indexed entry past the count reads as zero
	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.item_valid |->
			rsp.item_x == '0 && rsp.item_y == '0 && rsp.item_glyph == '0)
		else $error("indexed entry not cleared when out of range");

	// the count never passes the capacity and a valid index means a nonempty deque
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (CAPACITY > 511) ||
			((int'(rsp.entry_count) <= CAPACITY) &&
			(!rsp.item_valid || rsp.entry_count != '0)))
		else $error("entry count out of range");

	// the back end takes one operation at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready |=> !pop_ready)
		else $error("back end took a second operation while busy");
endmodule

@@ verif/bounded_position_deque_core_tb.sv @@
// self-checking testbench for the bounded position deque core
`timescale 1ns / 1ps

module bounded_position_deque_core_tb;
	import bpd_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int MAX_REPORTS  = 10;

	// codes outside the defined command set
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		entry_t             ent;
		logic [INDEX_W-1:0] idx;
	} deque_req_t;

	typedef struct packed {
		logic               accepted;
		logic [COUNT_W-1:0] count;
		entry_t             head;
		entry_t             tail;
		entry_t             item;
		logic               item_valid;
	} deque_rsp_t;

	logic clk;
	logic arst_n;

	bpd_req_if req_ch ();
	bpd_rsp_if rsp_ch ();

	bounded_position_deque_core #(
		.CAPACITY(CAP)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	deque_req_t req_backlog_q[$];
	deque_rsp_t rsp_want_q[$];
	entry_t     deque_image[$];

	int gen_count;
	int errors;
	int mismatches;
	int n_sent;
	int n_checked;
	int n_full_refused;
	int n_empty_refused;
	int n_item_hits;
	int peak_count;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// expected response for one request, updating the shadow deque
	function automatic deque_rsp_t deque_apply(deque_req_t r);
		deque_rsp_t p;
		p = '0;
		case (r.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (deque_image.size() < CAP) begin
					if (r.cmd == CMD_INS_HEAD)
						deque_image.push_front(r.ent);
					else
						deque_image.push_back(r.ent);
					p.accepted = 1'b1;
				end else begin
					n_full_refused++;
				end
			end
			CMD_REM_HEAD, CMD_REM_TAIL: begin
				if (deque_image.size() > 0) begin
					if (r.cmd == CMD_REM_HEAD)
						void'(deque_image.pop_front());
					else
						void'(deque_image.pop_back());
					p.accepted = 1'b1;
				end else begin
					n_empty_refused++;
				end
			end
			CMD_QUERY: p.accepted = 1'b1;
			default: ;
		endcase
		p.count = COUNT_W'(deque_image.size());
		if (deque_image.size() > 0) begin
			p.head = deque_image[0];
			p.tail = deque_image[$];
		end
		if (r.idx < deque_image.size()) begin
			p.item       = deque_image[r.idx];
			p.item_valid = 1'b1;
			n_item_hits++;
		end
		if (deque_image.size() > peak_count)
			peak_count = deque_image.size();
		return p;
	endfunction

	function automatic entry_t rand_entry();
		entry_t e;
		case ($urandom_range(0, 7))
			0: e = '0;
			1: e = '1;
			default: begin
				e.x     = COORD_W'($urandom);
				e.y     = COORD_W'($urandom);
				e.glyph = COORD_W'($urandom);
			end
		endcase
		return e;
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index(int count);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return INDEX_W'((count > 0) ? count - 1 : 0);
			3: return INDEX_W'(count);
			4, 5: return INDEX_W'($urandom_range(0, 255));
			default: return INDEX_W'($urandom_range(0, (count > 0) ? count - 1 : 0));
		endcase
	endfunction

	// queue one request and track the count it leaves behind
	task automatic queue_item(logic [CMD_W-1:0] cmd, entry_t e, logic [INDEX_W-1:0] idx);
		deque_req_t r;
		r.cmd = cmd;
		r.ent = e;
		r.idx = idx;
		req_backlog_q.push_back(r);
		case (cmd)
			CMD_INS_HEAD, CMD_INS_TAIL: if (gen_count < CAP) gen_count++;
			CMD_REM_HEAD, CMD_REM_TAIL: if (gen_count > 0) gen_count--;
			default: ;
		endcase
	endtask

	task automatic queue_random(logic [CMD_W-1:0] cmd);
		queue_item(cmd, rand_entry(), pick_index(gen_count));
	endtask

	// driver: bursts of transactions separated by random gaps
	int         burst_left;
	int         gap_left;
	deque_req_t cur_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.cmd        <= '0;
			req_ch.pos_x      <= '0;
			req_ch.pos_y      <= '0;
			req_ch.glyph      <= '0;
			req_ch.read_index <= '0;
			burst_left = $urandom_range(1, 20);
			gap_left   = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				rsp_want_q.push_back(deque_apply(cur_req));
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (req_backlog_q.size() != 0) begin
					cur_req = req_backlog_q.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.cmd        <= cur_req.cmd;
					req_ch.pos_x      <= cur_req.ent.x;
					req_ch.pos_y      <= cur_req.ent.y;
					req_ch.glyph      <= cur_req.ent.glyph;
					req_ch.read_index <= cur_req.idx;
					burst_left--;
					if (burst_left <= 0) begin
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 20);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: rotating stall pattern on ready, compare against oldest prediction
	logic [15:0] stall_pat;
	int          pat_left;
	deque_rsp_t  got;
	deque_rsp_t  want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_pat = 16'hffff;
			pat_left  = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.accepted   = rsp_ch.accepted;
				got.count      = rsp_ch.entry_count;
				got.head       = {rsp_ch.head_glyph, rsp_ch.head_y, rsp_ch.head_x};
				got.tail       = {rsp_ch.tail_glyph, rsp_ch.tail_y, rsp_ch.tail_x};
				got.item       = {rsp_ch.item_glyph, rsp_ch.item_y, rsp_ch.item_x};
				got.item_valid = rsp_ch.item_valid;
				if (rsp_want_q.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: response with no request outstanding", $realtime);
				end else begin
					want = rsp_want_q.pop_front();
					n_checked++;
					if (got.accepted !== want.accepted || got.count !== want.count
						|| got.head !== want.head || got.tail !== want.tail
						|| got.item !== want.item || got.item_valid !== want.item_valid) begin
						errors++;
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: mismatch on response %0d", $realtime, n_checked);
							$display("  exp acc=%b cnt=%0d head=%h tail=%h item=%h iv=%b",
								want.accepted, want.count, want.head, want.tail,
								want.item, want.item_valid);
							$display("  got acc=%b cnt=%0d head=%h tail=%h item=%h iv=%b",
								got.accepted, got.count, got.head, got.tail,
								got.item, got.item_valid);
						end
					end
				end
			end
			if (pat_left <= 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hffff;
					1: stall_pat = 16'($urandom) | 16'h0001;
					default: stall_pat = 16'($urandom) | 16'($urandom) | 16'h0001;
				endcase
				pat_left = $urandom_range(16, 200);
			end else begin
				stall_pat = {stall_pat[14:0], stall_pat[15]};
				pat_left--;
			end
			rsp_ch.ready <= stall_pat[0];
		end
	end

	// cycles since the last transaction on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int     episode;
		int     len;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = '0;
		req_ch.pos_x      = '0;
		req_ch.pos_y      = '0;
		req_ch.glyph      = '0;
		req_ch.read_index = '0;
		rsp_ch.ready      = 1'b0;
		errors            = 0;
		mismatches        = 0;
		n_sent            = 0;
		n_checked         = 0;
		n_full_refused    = 0;
		n_empty_refused   = 0;
		n_item_hits       = 0;
		peak_count        = 0;
		gen_count         = 0;

		// directed: empty list, field extremes, unused codes, drain past empty
		queue_item(CMD_QUERY, '0, '0);
		queue_item(CMD_QUERY, '1, '1);
		queue_item(CMD_REM_HEAD, '1, '0);
		queue_item(CMD_REM_TAIL, '1, '0);
		queue_item(CMD_INS_HEAD, '1, 8'd0);
		queue_item(CMD_INS_TAIL, '0, 8'd1);
		queue_item(CMD_INS_HEAD, 24'h3ca55a, 8'd2);
		queue_item(CMD_INS_TAIL, 24'hc35aa5, 8'd3);
		queue_item(CMD_QUERY, '0, 8'd4);
		queue_item(CMD_QUERY, '0, '1);
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			queue_item(CMD_W'(c), '1, 8'd1);
		queue_item(CMD_REM_TAIL, '0, 8'd0);
		queue_item(CMD_REM_HEAD, '0, 8'd1);
		queue_item(CMD_INS_HEAD, 24'h817e18, 8'd0);
		queue_item(CMD_REM_HEAD, '0, 8'd0);
		queue_item(CMD_REM_HEAD, '0, 8'd0);
		queue_item(CMD_REM_TAIL, '0, 8'd0);
		queue_item(CMD_REM_TAIL, '0, 8'd0);
		queue_item(CMD_INS_TAIL, 24'h7f0180, 8'd0);
		queue_item(CMD_REM_HEAD, '0, 8'd0);

		// random: fill to full, drain to empty, then a mix of episodes
		episode = 0;
		while (req_backlog_q.size() < RANDOM_ITEMS) begin
			case ((episode == 0) ? 0 : (episode == 1) ? 2 : $urandom_range(0, 9))
				0, 1: begin
					while (gen_count < CAP) begin
						if ($urandom_range(0, 7) == 0)
							queue_random(CMD_QUERY);
						else
							queue_random($urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL);
					end
					repeat ($urandom_range(1, 3))
						queue_random($urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL);
				end
				2, 3: begin
					while (gen_count > 0) begin
						if ($urandom_range(0, 7) == 0)
							queue_random(CMD_QUERY);
						else
							queue_random($urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL);
					end
					repeat ($urandom_range(1, 3))
						queue_random($urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL);
				end
				9: begin
					repeat ($urandom_range(5, 15))
						queue_random(CMD_W'($urandom_range(0, 7)));
				end
				default: begin
					len = $urandom_range(20, 80);
					repeat (len) begin
						case ($urandom_range(0, 19))
							0, 1, 2, 3:     queue_random(CMD_INS_HEAD);
							4, 5, 6, 7:     queue_random(CMD_INS_TAIL);
							8, 9, 10, 11:   queue_random(CMD_REM_HEAD);
							12, 13, 14, 15: queue_random(CMD_REM_TAIL);
							19: queue_random(CMD_W'($urandom_range(CMD_UNUSED_FIRST,
								CMD_UNUSED_LAST)));
							default: queue_random(CMD_QUERY);
						endcase
					end
				end
			endcase
			episode++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (!(req_backlog_q.size() == 0 && !req_ch.valid && rsp_want_q.size() == 0)
			&& idle_cycles < IDLE_LIMIT)
			@(negedge clk);

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d idle cycles, %0d responses outstanding",
				idle_cycles, rsp_want_q.size());
			$display("== FAIL ==");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (rsp_want_q.size() != 0) begin
				errors += rsp_want_q.size();
				$display("%0d responses never arrived", rsp_want_q.size());
			end
			$display("covered %0d transactions, %0d responses checked, %0d mismatches",
				n_sent, n_checked, mismatches);
			$display("peak count %0d, %0d full inserts and %0d empty removals refused, %0d item hits",
				peak_count, n_full_refused, n_empty_refused, n_item_hits);
			if (errors == 0)
				$display("== PASS ==");
			else
				$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bpd_pkg.sv
rtl/bpd_if.sv
rtl/bpd_front.sv
rtl/bpd_fifo.sv
rtl/bpd_back.sv
rtl/bounded_position_deque_core.sv
verif/bounded_position_deque_core_tb.sv
